### rtl/lldw_pkg.sv
// Shared constants, tables and types for the LED line dither writer.
package lldw_pkg;

	localparam int LED_COUNT   = 56;
	localparam int TIME_SLOTS  = 8;
	localparam int LINE_BYTES  = 7;
	localparam int ANGLE_COUNT = 240;
	localparam int STORE_WIDTH = 24;
	localparam int CALC_W      = 17;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_READ  = 1'b1;

	localparam logic [1:0] COLOR_RED   = 2'd0;
	localparam logic [1:0] COLOR_GREEN = 2'd1;
	localparam logic [1:0] COLOR_BLUE  = 2'd2;

	localparam logic [2:0] LED_BYTE_POS [LED_COUNT] = '{
		3'd0, 3'd3, 3'd0, 3'd3, 3'd0, 3'd3, 3'd0, 3'd3,
		3'd0, 3'd4, 3'd0, 3'd4, 3'd0, 3'd4, 3'd0, 3'd4,
		3'd1, 3'd4, 3'd1, 3'd4, 3'd1, 3'd4, 3'd1, 3'd4,
		3'd1, 3'd5, 3'd1, 3'd5, 3'd1, 3'd5, 3'd1, 3'd5,
		3'd2, 3'd5, 3'd2, 3'd5, 3'd2, 3'd5, 3'd2, 3'd5,
		3'd2, 3'd6, 3'd2, 3'd6, 3'd2, 3'd6, 3'd2, 3'd6,
		3'd3, 3'd6, 3'd3, 3'd6, 3'd3, 3'd6, 3'd3, 3'd6
	};

	localparam logic [7:0] LED_BIT_MASK [LED_COUNT] = '{
		8'h01, 8'h10, 8'h02, 8'h20, 8'h04, 8'h40, 8'h08, 8'h80,
		8'h10, 8'h01, 8'h20, 8'h02, 8'h40, 8'h04, 8'h80, 8'h08,
		8'h01, 8'h10, 8'h02, 8'h20, 8'h04, 8'h40, 8'h08, 8'h80,
		8'h10, 8'h01, 8'h20, 8'h02, 8'h40, 8'h04, 8'h80, 8'h08,
		8'h01, 8'h10, 8'h02, 8'h20, 8'h04, 8'h40, 8'h08, 8'h80,
		8'h10, 8'h01, 8'h20, 8'h02, 8'h40, 8'h04, 8'h80, 8'h08,
		8'h01, 8'h10, 8'h02, 8'h20, 8'h04, 8'h40, 8'h08, 8'h80
	};

	// Bit s of a row is the on/off value of time slot s for that level.
	localparam logic [7:0] DITHER_ROW [8] = '{
		8'b0000_0000,
		8'b0001_0000,
		8'b0010_0100,
		8'b0100_1010,
		8'b1010_1010,
		8'b1011_0101,
		8'b1101_1011,
		8'b1110_1111
	};

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WRITE,
		ST_FLUSH,
		ST_READ
	} state_t;

	function automatic logic [2:0] sat_level(input logic [3:0] level);
		sat_level = level[3] ? 3'd7 : level[2:0];
	endfunction

endpackage

### rtl/led_line_dither_writer.sv
// Top level of the LED line dither writer: line store, dithered pixel writes and byte reads.
//
//   channel   direction  handshake             payload
//   in        input      in_valid / in_stall   operation, led_index, angle_index, levels,
//                                              read_line, read_byte, read_color
//   out       output     out_valid / out_stall read_data
//   cfg       input      cfg_valid / cfg_ready cfg_brightness
//
// A pixel write stalls the next input transaction while it does one read-modify-write of the
// store per time slot, eight slots through one read and one write port, overlapped read and
// write-back. A byte read stalls input until the output register can take its byte.
// After reset a clearing pass zeroes all ANGLE_COUNT * 56 store entries while in_stall is high;
// configuration writes are taken at any time.
module led_line_dither_writer #(
	parameter int ANGLE_COUNT = lldw_pkg::ANGLE_COUNT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        operation,
	input  logic [5:0]  led_index,
	input  logic [7:0]  angle_index,
	input  logic [3:0]  red_level,
	input  logic [3:0]  green_level,
	input  logic [3:0]  blue_level,
	input  logic [10:0] read_line,
	input  logic [2:0]  read_byte,
	input  logic [1:0]  read_color,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  read_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_brightness
);

	localparam int LINE_TOTAL = ANGLE_COUNT * lldw_pkg::TIME_SLOTS;
	localparam int DEPTH      = LINE_TOTAL * lldw_pkg::LINE_BYTES;
	localparam int AW         = $clog2(DEPTH);
	localparam int SW         = lldw_pkg::STORE_WIDTH;
	localparam int CW         = lldw_pkg::CALC_W;
	localparam int LINE_STEP  = lldw_pkg::LINE_BYTES;

	localparam logic [10:0] ANGLE_LIM = 11'(ANGLE_COUNT);
	localparam logic [13:0] LINE_LIM  = 14'(LINE_TOTAL);
	localparam logic [5:0]  LED_LIM   = 6'(lldw_pkg::LED_COUNT);
	localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);

	lldw_pkg::state_t state_q, state_d;

	logic [AW-1:0]   clr_addr_q;
	logic [2:0]      rd_slot_q;
	logic [AW-1:0]   rd_addr_q;
	logic            wr_valid_s1;
	logic [AW-1:0]   wr_addr_s1;
	logic [2:0]      wr_slot_s1;
	logic [7:0]      mask_q;
	logic [2:0][7:0] pat_q;
	logic            rd_mem_q;
	logic            rd_trl_q;
	logic [1:0]      rd_color_q;
	logic            out_valid_q;
	logic [7:0]      read_data_q;
	logic [7:0]      bright_q;

	logic            accept;
	logic            write_ok;
	logic            read_in_range;
	logic            read_trailer;
	logic [CW-1:0]   base_calc;
	logic [CW-1:0]   read_calc;
	logic            out_load;
	logic [7:0]      sel_byte;

	logic            mem_we;
	logic [AW-1:0]   mem_waddr;
	logic [SW-1:0]   mem_wdata;
	logic            mem_re;
	logic [AW-1:0]   mem_raddr;
	logic [SW-1:0]   mem_rdata;
	logic [SW-1:0]   mod_data;

	lldw_ram #(
		.WIDTH(SW),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign in_stall  = (state_q != lldw_pkg::ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign read_data = read_data_q;

	assign write_ok = (led_index < LED_LIM) && (11'(angle_index) < ANGLE_LIM);
	assign read_in_range = (14'(read_line) < LINE_LIM) &&
		(read_byte < 3'(lldw_pkg::LINE_BYTES)) && (read_color != 2'd3);
	assign read_trailer = (14'(read_line) == LINE_LIM) && (read_byte == 3'd0) &&
		(read_color == lldw_pkg::COLOR_RED);

	// Address of a line byte is line * 7 + byte; angle a starts at line 8a, so at entry 56a.
	assign base_calc = (CW'(angle_index) << 6) - (CW'(angle_index) << 3) +
		CW'(lldw_pkg::LED_BYTE_POS[led_index]);
	assign read_calc = (CW'(read_line) << 3) - CW'(read_line) + CW'(read_byte);

	assign out_load = (state_q == lldw_pkg::ST_READ) && (!out_valid_q || !out_stall);

	always_comb begin
		mod_data = mem_rdata;
		for (int c = 0; c < 3; c++) begin
			if (pat_q[c][wr_slot_s1]) begin
				mod_data[c*8 +: 8] = mem_rdata[c*8 +: 8] | mask_q;
			end else begin
				mod_data[c*8 +: 8] = mem_rdata[c*8 +: 8] & ~mask_q;
			end
		end
	end

	always_comb begin
		unique case (rd_color_q)
			lldw_pkg::COLOR_RED:   sel_byte = mem_rdata[7:0];
			lldw_pkg::COLOR_GREEN: sel_byte = mem_rdata[15:8];
			lldw_pkg::COLOR_BLUE:  sel_byte = mem_rdata[23:16];
			default:               sel_byte = 8'd0;
		endcase
	end

	always_comb begin
		state_d   = state_q;
		mem_re    = 1'b0;
		mem_raddr = rd_addr_q;
		mem_we    = wr_valid_s1;
		mem_waddr = wr_addr_s1;
		mem_wdata = mod_data;
		unique case (state_q)
			lldw_pkg::ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_addr_q;
				mem_wdata = '0;
				if (clr_addr_q == CLR_LAST) begin
					state_d = lldw_pkg::ST_IDLE;
				end
			end
			lldw_pkg::ST_IDLE: begin
				if (accept) begin
					if (operation == lldw_pkg::OP_READ) begin
						mem_re    = read_in_range;
						mem_raddr = AW'(read_calc);
						state_d   = lldw_pkg::ST_READ;
					end else if (write_ok) begin
						state_d = lldw_pkg::ST_WRITE;
					end
				end
			end
			lldw_pkg::ST_WRITE: begin
				mem_re = 1'b1;
				if (rd_slot_q == 3'(lldw_pkg::TIME_SLOTS - 1)) begin
					state_d = lldw_pkg::ST_FLUSH;
				end
			end
			lldw_pkg::ST_FLUSH: begin
				state_d = lldw_pkg::ST_IDLE;
			end
			lldw_pkg::ST_READ: begin
				if (out_load) begin
					state_d = lldw_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lldw_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lldw_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q  <= '0;
			rd_slot_q   <= '0;
			wr_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			bright_q    <= '0;
		end else begin
			if (state_q == lldw_pkg::ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
			if (state_q == lldw_pkg::ST_WRITE) begin
				rd_slot_q <= rd_slot_q + 3'd1;
			end else begin
				rd_slot_q <= '0;
			end
			wr_valid_s1 <= (state_q == lldw_pkg::ST_WRITE);
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				bright_q <= cfg_brightness;
			end
		end
	end

	always_ff @(posedge clk) begin
		wr_addr_s1 <= rd_addr_q;
		wr_slot_s1 <= rd_slot_q;
		if (state_q == lldw_pkg::ST_WRITE) begin
			rd_addr_q <= rd_addr_q + AW'(LINE_STEP);
		end
		if (accept) begin
			rd_addr_q  <= AW'(base_calc);
			mask_q     <= lldw_pkg::LED_BIT_MASK[led_index];
			pat_q[0]   <= lldw_pkg::DITHER_ROW[lldw_pkg::sat_level(red_level)];
			pat_q[1]   <= lldw_pkg::DITHER_ROW[lldw_pkg::sat_level(green_level)];
			pat_q[2]   <= lldw_pkg::DITHER_ROW[lldw_pkg::sat_level(blue_level)];
			rd_mem_q   <= read_in_range;
			rd_trl_q   <= read_trailer;
			rd_color_q <= read_color;
		end
		if (out_load) begin
			if (rd_mem_q) begin
				read_data_q <= sel_byte;
			end else if (rd_trl_q) begin
				read_data_q <= bright_q;
			end else begin
				read_data_q <= 8'd0;
			end
		end
	end

endmodule

### rtl/lldw_ram.sv
// Generic single write port, single read port RAM with registered read data.
module lldw_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 13440
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### sim/lldw_line_checker.sv
// Checker for the LED line dither writer: mirrors the line store, predicts read bytes and compares.
module lldw_line_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic        operation,
	input  logic [5:0]  led_index,
	input  logic [7:0]  angle_index,
	input  logic [3:0]  red_level,
	input  logic [3:0]  green_level,
	input  logic [3:0]  blue_level,
	input  logic [10:0] read_line,
	input  logic [2:0]  read_byte,
	input  logic [1:0]  read_color,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [7:0]  read_data,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [7:0]  cfg_brightness,
	output int          fail_count,
	output int          pending,
	output int          checked
);
	import lldw_pkg::*;

	localparam int LINE_TOTAL = ANGLE_COUNT * TIME_SLOTS;

	localparam logic [7:0] SLOT_PATTERN [8] = '{
		8'b0000_0000,
		8'b0001_0000,
		8'b0010_0100,
		8'b0100_1010,
		8'b1010_1010,
		8'b1011_0101,
		8'b1101_1011,
		8'b1110_1111
	};

	logic [23:0] line_image [LINE_TOTAL * LINE_BYTES];
	logic [7:0]  brightness_copy;
	logic [7:0]  expected_bytes [$];
	logic [7:0]  oldest;

	function automatic int led_column(input logic [5:0] led);
		int group;
		group = led / 8;
		if (led[0]) begin
			return 3 + (group + 1) / 2;
		end
		return group / 2;
	endfunction

	function automatic logic [7:0] led_bit(input logic [5:0] led);
		logic [7:0] m;
		m = 8'h01 << ((led % 8) / 2);
		if (((led / 8) % 2) != led[0]) begin
			m = m << 4;
		end
		return m;
	endfunction

	function automatic logic [2:0] clamp_level(input logic [3:0] level);
		return level > 4'd7 ? 3'd7 : level[2:0];
	endfunction

	task automatic paint_pixel(input logic [5:0] led, input logic [7:0] ang,
			input logic [3:0] r, input logic [3:0] g, input logic [3:0] b);
		logic [2:0]  levels [3];
		logic [23:0] word;
		logic [23:0] m;
		int          entry;
		if (led >= LED_COUNT || ang >= ANGLE_COUNT) begin
			return;
		end
		levels[0] = clamp_level(r);
		levels[1] = clamp_level(g);
		levels[2] = clamp_level(b);
		for (int s = 0; s < TIME_SLOTS; s++) begin
			entry = (int'(ang) * TIME_SLOTS + s) * LINE_BYTES + led_column(led);
			word = line_image[entry];
			for (int c = 0; c < 3; c++) begin
				m = 24'(led_bit(led)) << (8 * c);
				if (SLOT_PATTERN[levels[c]][s]) begin
					word = word | m;
				end else begin
					word = word & ~m;
				end
			end
			line_image[entry] = word;
		end
	endtask

	function automatic logic [7:0] stored_byte(input logic [10:0] line,
			input logic [2:0] byte_sel, input logic [1:0] color_sel);
		if (color_sel < 2'd3 && byte_sel < LINE_BYTES) begin
			if (line < LINE_TOTAL) begin
				return line_image[int'(line) * LINE_BYTES + byte_sel][8 * color_sel +: 8];
			end else if (line == LINE_TOTAL && byte_sel == 3'd0 && color_sel == COLOR_RED) begin
				return brightness_copy;
			end
		end
		return 8'h00;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LINE_TOTAL * LINE_BYTES; i++) begin
				line_image[i] = '0;
			end
			brightness_copy = 8'h00;
			expected_bytes.delete();
			fail_count = 0;
			pending = 0;
			checked = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				brightness_copy = cfg_brightness;
			end
			if (out_valid && !out_stall) begin
				if (expected_bytes.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected read_data transaction, expected none, actual %02h",
						$time, read_data);
				end else begin
					oldest = expected_bytes.pop_front();
					checked++;
					if (read_data !== oldest) begin
						fail_count++;
						$display("%0t: read_data mismatch, expected %02h, actual %02h",
							$time, oldest, read_data);
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (operation == OP_READ) begin
					expected_bytes.push_back(stored_byte(read_line, read_byte, read_color));
				end else begin
					paint_pixel(led_index, angle_index, red_level, green_level, blue_level);
				end
			end
			pending = expected_bytes.size();
		end
	end

endmodule

### sim/led_line_dither_writer_tb.sv
// Testbench top for the LED line dither writer: clock, reset, stimulus and verdict.
module led_line_dither_writer_tb;
	import lldw_pkg::*;

	localparam int HOLD_CYCLES = 400;
	localparam int PHASES = 4;
	localparam int PHASE_ITEMS = 400;
	localparam logic [10:0] TRAILER_LINE = 11'(ANGLE_COUNT * TIME_SLOTS);

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        operation;
	logic [5:0]  led_index;
	logic [7:0]  angle_index;
	logic [3:0]  red_level;
	logic [3:0]  green_level;
	logic [3:0]  blue_level;
	logic [10:0] read_line;
	logic [2:0]  read_byte;
	logic [1:0]  read_color;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  read_data;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_brightness;

	int fail_count;
	int pending;
	int checked;

	bit quiet;
	bit hold_req;
	int writes_sent;
	int ignored_writes;
	int reads_sent;
	int trailer_reads;
	int settings_used;

	led_line_dither_writer uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.operation      (operation),
		.led_index      (led_index),
		.angle_index    (angle_index),
		.red_level      (red_level),
		.green_level    (green_level),
		.blue_level     (blue_level),
		.read_line      (read_line),
		.read_byte      (read_byte),
		.read_color     (read_color),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.read_data      (read_data),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_brightness (cfg_brightness)
	);

	lldw_line_checker line_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.operation      (operation),
		.led_index      (led_index),
		.angle_index    (angle_index),
		.red_level      (red_level),
		.green_level    (green_level),
		.blue_level     (blue_level),
		.read_line      (read_line),
		.read_byte      (read_byte),
		.read_color     (read_color),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.read_data      (read_data),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_brightness (cfg_brightness),
		.fail_count     (fail_count),
		.pending        (pending),
		.checked        (checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end
			out_stall = !quiet && ($urandom_range(99) < 24);
		end
	end

	task automatic push_item(input logic op, input logic [5:0] led, input logic [7:0] ang,
			input logic [3:0] r, input logic [3:0] g, input logic [3:0] b,
			input logic [10:0] line, input logic [2:0] byte_sel, input logic [1:0] color_sel);
		if (!quiet && $urandom_range(99) < 24) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		operation = op;
		led_index = led;
		angle_index = ang;
		red_level = r;
		green_level = g;
		blue_level = b;
		read_line = line;
		read_byte = byte_sel;
		read_color = color_sel;
		in_valid = 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
		if (op == OP_READ) begin
			reads_sent++;
			if (line == TRAILER_LINE) begin
				trailer_reads++;
			end
		end else begin
			writes_sent++;
			if (led >= LED_COUNT || ang >= ANGLE_COUNT) begin
				ignored_writes++;
			end
		end
	endtask

	task automatic pixel_write(input logic [5:0] led, input logic [7:0] ang,
			input logic [3:0] r, input logic [3:0] g, input logic [3:0] b);
		push_item(OP_WRITE, led, ang, r, g, b, 11'($urandom), 3'($urandom), 2'($urandom));
	endtask

	task automatic byte_read(input logic [10:0] line, input logic [2:0] byte_sel,
			input logic [1:0] color_sel);
		push_item(OP_READ, 6'($urandom), 8'($urandom), 4'($urandom), 4'($urandom),
			4'($urandom), line, byte_sel, color_sel);
	endtask

	task automatic random_read(input int base_angle);
		int pick;
		pick = $urandom_range(99);
		if (pick < 70) begin
			byte_read(11'(base_angle * TIME_SLOTS + $urandom_range(0, 31)),
				3'($urandom_range(0, 6)), 2'($urandom_range(0, 2)));
		end else if (pick < 80) begin
			byte_read(TRAILER_LINE, 3'($urandom_range(0, 1)), 2'($urandom_range(0, 1)));
		end else if (pick < 90) begin
			byte_read(11'($urandom), 3'($urandom), 2'($urandom));
		end else begin
			byte_read(11'($urandom_range(0, ANGLE_COUNT * TIME_SLOTS - 1)),
				3'($urandom_range(0, 6)), 2'($urandom_range(0, 2)));
		end
	endtask

	task automatic random_item(input int base_angle);
		logic [5:0] led;
		logic [7:0] ang;
		if ($urandom_range(99) < 55) begin
			led = ($urandom_range(99) < 6) ? 6'($urandom_range(56, 63)) : 6'($urandom_range(0, 55));
			ang = ($urandom_range(99) < 8) ? 8'($urandom) : 8'(base_angle + $urandom_range(0, 3));
			pixel_write(led, ang, 4'($urandom), 4'($urandom), 4'($urandom));
		end else begin
			random_read(base_angle);
		end
	endtask

	task automatic set_brightness(input logic [7:0] value);
		in_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		cfg_brightness = value;
		cfg_valid = 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
		settings_used++;
	endtask

	initial begin
		int base_angle;
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = OP_WRITE;
		led_index = '0;
		angle_index = '0;
		red_level = '0;
		green_level = '0;
		blue_level = '0;
		read_line = '0;
		read_byte = '0;
		read_color = '0;
		cfg_valid = 1'b0;
		cfg_brightness = '0;
		quiet = 1'b0;
		hold_req = 1'b0;
		writes_sent = 0;
		ignored_writes = 0;
		reads_sent = 0;
		trailer_reads = 0;
		settings_used = 0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		byte_read(TRAILER_LINE, 3'd0, COLOR_RED);
		set_brightness(8'hFF);
		byte_read(TRAILER_LINE, 3'd0, COLOR_RED);
		byte_read(TRAILER_LINE, 3'd1, COLOR_RED);
		byte_read(TRAILER_LINE, 3'd0, COLOR_GREEN);
		pixel_write(6'd0, 8'd0, 4'd0, 4'd7, 4'd15);
		pixel_write(6'd55, 8'd239, 4'd15, 4'd8, 4'd4);
		pixel_write(6'd56, 8'd0, 4'd7, 4'd7, 4'd7);
		pixel_write(6'd63, 8'd5, 4'd7, 4'd7, 4'd7);
		pixel_write(6'd3, 8'd240, 4'd7, 4'd7, 4'd7);
		pixel_write(6'd3, 8'd255, 4'd7, 4'd7, 4'd7);
		byte_read(11'd0, 3'd0, COLOR_RED);
		byte_read(11'd0, 3'd0, COLOR_GREEN);
		byte_read(11'd4, 3'd0, COLOR_BLUE);
		byte_read(11'd1919, 3'd6, COLOR_BLUE);
		byte_read(11'd1912, 3'd6, COLOR_RED);
		byte_read(11'd0, 3'd7, COLOR_RED);
		byte_read(11'd0, 3'd0, 2'd3);
		byte_read(11'd2047, 3'd7, 2'd3);
		byte_read(TRAILER_LINE + 11'd1, 3'd0, COLOR_RED);
		pixel_write(6'd9, 8'd1, 4'd1, 4'd4, 4'd6);
		byte_read(11'd8, 3'd4, COLOR_GREEN);
		byte_read(11'd12, 3'd4, COLOR_BLUE);
		pixel_write(6'd0, 8'd0, 4'd7, 4'd0, 4'd3);
		byte_read(11'd3, 3'd0, COLOR_RED);

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin
					set_brightness(8'h00);
				end
				1: begin
					set_brightness(8'h80);
				end
				default: begin
					set_brightness(8'($urandom));
				end
			endcase
			base_angle = (p == PHASES - 1) ? ANGLE_COUNT - 4 : $urandom_range(0, ANGLE_COUNT - 4);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				quiet = (p == 2 && k < 200);
				if (p == 1 && k == 100) begin
					hold_req = 1'b1;
					for (int n = 0; n < 60; n++) begin
						random_read(base_angle);
					end
				end else begin
					random_item(base_angle);
				end
			end
		end
		quiet = 1'b0;

		in_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (30) @(negedge clk);
		$display("Run covered %0d pixel writes (%0d outside bar or angle range) and %0d byte reads",
			writes_sent, ignored_writes, reads_sent);
		$display("with %0d trailer reads, %0d brightness settings and %0d checked read bytes.",
			trailer_reads, settings_used, checked);
		if (fail_count == 0 && pending == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

### led_line_dither_writer.f
rtl/lldw_pkg.sv
rtl/lldw_ram.sv
rtl/led_line_dither_writer.sv
sim/lldw_line_checker.sv
sim/led_line_dither_writer_tb.sv
